// File: rtl/deq_pkg.sv
// Shared types, sizes and ring arithmetic for the double-ended queue core.
// No dependencies; every other file but deq_ram refers to it by scoped names.
package deq_pkg;

   localparam int DEPTH  = 16;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int OCC_W  = 7;
   localparam int DATA_W = 32;

   typedef logic [ADDR_W-1:0]        addr_type;
   typedef logic [CNT_W-1:0]         cnt_type;
   typedef logic [CNT_W:0]           sum_type;
   typedef logic [OCC_W-1:0]         occ_type;
   typedef logic signed [DATA_W-1:0] data_type;

   typedef enum logic [2:0] {
      ACT_PUSH_FRONT = 3'd0,
      ACT_PUSH_BACK  = 3'd1,
      ACT_POP_FRONT  = 3'd2,
      ACT_POP_BACK   = 3'd3,
      ACT_DUMP       = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_POP,
      S_DUMP
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic       push_front;
      logic       push_back;
      logic       pop_front;
      logic       pop_back;
      logic       dump_first;
      logic       dump_next;
      logic       rsp_load;
      logic       rsp_from_mem;
      status_type rsp_status;
      logic       rsp_last;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic empty;
      logic full;
      logic dump_last;
   } sts_type;

   // (pos + off) mod DEPTH, with pos < DEPTH and off <= DEPTH
   function automatic addr_type ring_add(input addr_type pos, input cnt_type off);
      sum_type sum;
      sum = sum_type'(pos) + sum_type'(off);
      if (sum >= sum_type'(DEPTH)) begin
         sum = sum - sum_type'(DEPTH);
      end
      return addr_type'(sum);
   endfunction

   function automatic addr_type ring_dec(input addr_type pos);
      if (pos == addr_type'(0)) begin
         return addr_type'(DEPTH - 1);
      end
      return pos - addr_type'(1);
   endfunction

endpackage

// File: rtl/deq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic                                  re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/deq_ctrl.sv
// Request sequencer for the double-ended queue: decodes the action and walks pops/dumps.
// Depends on deq_pkg.
module deq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [2:0]       req_action,
   input  deq_pkg::sts_type sts,
   output deq_pkg::cmd_type cmd,
   output logic             busy
);

   deq_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= deq_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      deq_pkg::action_type act;
      act      = deq_pkg::action_type'(req_action);
      state_in = state_ff;
      cmd      = '0;
      cmd.rsp_status = deq_pkg::ST_OK;
      busy     = 1'b1;
      unique case (state_ff)
         deq_pkg::S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               unique case (act) inside
                  deq_pkg::ACT_PUSH_FRONT, deq_pkg::ACT_PUSH_BACK: begin
                     cmd.rsp_load = 1'b1;
                     cmd.rsp_last = 1'b1;
                     if (sts.full) begin
                        cmd.rsp_status = deq_pkg::ST_FULL;
                     end else begin
                        cmd.push_front = (act == deq_pkg::ACT_PUSH_FRONT);
                        cmd.push_back  = (act == deq_pkg::ACT_PUSH_BACK);
                     end
                  end
                  deq_pkg::ACT_POP_FRONT, deq_pkg::ACT_POP_BACK: begin
                     if (sts.empty) begin
                        cmd.rsp_load   = 1'b1;
                        cmd.rsp_last   = 1'b1;
                        cmd.rsp_status = deq_pkg::ST_EMPTY;
                     end else begin
                        cmd.pop_front = (act == deq_pkg::ACT_POP_FRONT);
                        cmd.pop_back  = (act == deq_pkg::ACT_POP_BACK);
                        state_in      = deq_pkg::S_POP;
                     end
                  end
                  deq_pkg::ACT_DUMP: begin
                     if (sts.empty) begin
                        cmd.rsp_load   = 1'b1;
                        cmd.rsp_last   = 1'b1;
                        cmd.rsp_status = deq_pkg::ST_EMPTY;
                     end else begin
                        cmd.dump_first = 1'b1;
                        state_in       = deq_pkg::S_DUMP;
                     end
                  end
                  default: begin
                     // unknown action: a single empty-handed ok beat
                     cmd.rsp_load = 1'b1;
                     cmd.rsp_last = 1'b1;
                  end
               endcase
            end
         end
         deq_pkg::S_POP: begin
            cmd.rsp_load     = 1'b1;
            cmd.rsp_from_mem = 1'b1;
            cmd.rsp_last     = 1'b1;
            state_in         = deq_pkg::S_IDLE;
         end
         deq_pkg::S_DUMP: begin
            cmd.rsp_load     = 1'b1;
            cmd.rsp_from_mem = 1'b1;
            cmd.rsp_last     = sts.dump_last;
            if (sts.dump_last) begin
               state_in = deq_pkg::S_IDLE;
            end else begin
               cmd.dump_next = 1'b1;
            end
         end
         default: begin
            state_in = deq_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/deq_dpath.sv
// Datapath of the double-ended queue: ring pointers, count, value RAM, result registers.
// Depends on deq_pkg and deq_ram.
module deq_dpath (
   input  logic                   clock,
   input  logic                   reset,
   input  deq_pkg::cmd_type       cmd,
   input  deq_pkg::data_type      req_value,
   output deq_pkg::sts_type       sts,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_status,
   output logic signed [31:0]     rsp_item,
   output logic                   rsp_last,
   output logic [6:0]             rsp_occupancy
);

   deq_pkg::addr_type front_ff, front_in;
   deq_pkg::cnt_type  count_ff, count_in;
   deq_pkg::addr_type dptr_ff, dptr_in;
   deq_pkg::cnt_type  idx_ff, idx_in;

   logic                          rsp_valid_ff;
   deq_pkg::status_type           rsp_status_ff;
   deq_pkg::data_type             rsp_item_ff;
   logic                          rsp_last_ff;
   deq_pkg::occ_type              rsp_occ_ff;

   logic                          ram_we, ram_re;
   deq_pkg::addr_type             ram_waddr, ram_raddr;
   logic [deq_pkg::DATA_W-1:0]    ram_rdata;

   always_comb begin
      front_in  = front_ff;
      count_in  = count_ff;
      dptr_in   = dptr_ff;
      idx_in    = idx_ff;
      ram_we    = cmd.push_front | cmd.push_back;
      ram_re    = cmd.pop_front | cmd.pop_back | cmd.dump_first | cmd.dump_next;
      ram_waddr = deq_pkg::ring_add(front_ff, count_ff);
      ram_raddr = front_ff;

      if (cmd.push_front) begin
         ram_waddr = deq_pkg::ring_dec(front_ff);
         front_in  = ram_waddr;
      end
      if (cmd.push_front || cmd.push_back) begin
         count_in = count_ff + deq_pkg::cnt_type'(1);
      end
      if (cmd.pop_front) begin
         front_in = deq_pkg::ring_add(front_ff, deq_pkg::cnt_type'(1));
      end
      if (cmd.pop_back) begin
         ram_raddr = deq_pkg::ring_add(front_ff, count_ff - deq_pkg::cnt_type'(1));
      end
      if (cmd.pop_front || cmd.pop_back) begin
         count_in = count_ff - deq_pkg::cnt_type'(1);
      end
      if (cmd.dump_first) begin
         dptr_in = front_ff;
         idx_in  = '0;
      end
      if (cmd.dump_next) begin
         ram_raddr = deq_pkg::ring_add(dptr_ff, deq_pkg::cnt_type'(1));
         dptr_in   = ram_raddr;
         idx_in    = idx_ff + deq_pkg::cnt_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         count_ff     <= count_in;
         rsp_valid_ff <= cmd.rsp_load;
      end
   end

   always_ff @(posedge clock) begin
      dptr_ff <= dptr_in;
      idx_ff  <= idx_in;
      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_item_ff   <= cmd.rsp_from_mem ? deq_pkg::data_type'(ram_rdata) : '0;
         rsp_last_ff   <= cmd.rsp_last;
         rsp_occ_ff    <= deq_pkg::occ_type'(count_in);
      end
   end

   deq_ram #(
      .WIDTH (deq_pkg::DATA_W),
      .DEPTH (deq_pkg::DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (req_value),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign sts.empty     = (count_ff == '0);
   assign sts.full      = (count_ff == deq_pkg::cnt_type'(deq_pkg::DEPTH));
   assign sts.dump_last = (idx_ff == count_ff - deq_pkg::cnt_type'(1));

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_item      = rsp_item_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_occupancy = rsp_occ_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= deq_pkg::cnt_type'(deq_pkg::DEPTH))
      else $error("stored count beyond depth");

   a_front_bound: assert property (@(posedge clock) disable iff (reset)
      front_ff < deq_pkg::addr_type'(deq_pkg::DEPTH - 1) ||
      front_ff == deq_pkg::addr_type'(deq_pkg::DEPTH - 1))
      else $error("front pointer off the ring");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      (cmd.push_front || cmd.push_back) |-> !sts.full)
      else $error("write issued into a full queue");

   a_no_read_empty: assert property (@(posedge clock) disable iff (reset)
      (cmd.pop_front || cmd.pop_back || cmd.dump_first) |-> !sts.empty)
      else $error("read issued on an empty queue");

   a_dump_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |=> rsp_valid_ff)
      else $error("dump beat sequence broken before its last beat");

endmodule

// File: rtl/double_ended_queue_core.sv
// Top level of the double-ended queue core: ties the sequencer to the datapath.
// Depends on deq_pkg, deq_ctrl, deq_dpath (and through it deq_ram).
//
//   channel   ports                                    handshake
//   request   req_action, req_value                    start & !busy
//   result    rsp_status, rsp_item, rsp_last,           rsp_valid, one cycle
//             rsp_occupancy
//
// Push, full/empty rejects and unknown actions are decided in the idle state, result the next cycle.
// Pops pass through S_POP; the value RAM read is registered, then the result register.
// A dump starts in the idle state, then S_DUMP gives one beat per stored value, one beat per RAM read.
// Reset clears the front pointer, count and rsp_valid; the dump pointer and the value RAM are never cleared.
// Results cannot be held off, so nothing in the core waits on the receiver.
module double_ended_queue_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_action,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_item,
   output logic               rsp_last,
   output logic [6:0]         rsp_occupancy
);

   deq_pkg::cmd_type cmd;
   deq_pkg::sts_type sts;

   deq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .sts        (sts),
      .cmd        (cmd),
      .busy       (busy)
   );

   deq_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_value     (req_value),
      .sts           (sts),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_item      (rsp_item),
      .rsp_last      (rsp_last),
      .rsp_occupancy (rsp_occupancy)
   );

endmodule

// File: dv/double_ended_queue_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for double_ended_queue_core: queued request beats, random gaps,
// and a behavioral deque that predicts every result beat. Depends on deq_pkg and the RTL.
module double_ended_queue_core_test;

   localparam logic [2:0] ACT_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] ACT_UNUSED_LAST  = 3'd7;
   localparam int QUIET_LIMIT = 4000;
   localparam int PRINT_CAP   = 40;

   typedef struct {
      logic [2:0]        action;
      deq_pkg::data_type value;
      int                idle_pct;
   } deq_request_type;

   typedef struct {
      deq_pkg::status_type status;
      deq_pkg::data_type   item;
      logic                last;
      deq_pkg::occ_type    occ;
   } deq_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [2:0]         req_action = '0;
   logic signed [31:0] req_value = '0;
   logic               rsp_valid;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_item;
   logic               rsp_last;
   logic [6:0]         rsp_occupancy;

   deq_request_type pending_requests[$];
   deq_result_type  expected_results[$];
   deq_request_type next_beat;

   // behavioral deque state
   deq_pkg::data_type shadow_store[deq_pkg::DEPTH];
   int       shadow_front = 0;
   int       shadow_count = 0;
   int       gen_count    = 0;

   logic beat_taken  = 1'b0;
   int   quiet_cycles = 0;
   int   mismatches   = 0;
   int   items_accepted = 0;
   int   results_checked = 0;
   int   full_rejects = 0;
   int   empty_reports = 0;
   int   dump_beats = 0;
   int   unknown_actions = 0;
   int   peak_occupancy = 0;

   always #4 clock = ~clock;

   double_ended_queue_core i_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_action    (req_action),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_item      (rsp_item),
      .rsp_last      (rsp_last),
      .rsp_occupancy (rsp_occupancy)
   );

   task automatic report_mismatch(input string msg);
      if (mismatches < PRINT_CAP) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
      mismatches++;
   endtask

   task automatic push_expected(input deq_pkg::status_type st, input deq_pkg::data_type item,
                                input logic last);
      deq_result_type r;
      r.status = st;
      r.item   = item;
      r.last   = last;
      r.occ    = deq_pkg::occ_type'(shadow_count);
      expected_results.push_back(r);
   endtask

   task automatic predict_deque_results(input logic [2:0] act, input deq_pkg::data_type val);
      int i;
      case (act)
         deq_pkg::ACT_PUSH_FRONT, deq_pkg::ACT_PUSH_BACK: begin
            if (shadow_count == deq_pkg::DEPTH) begin
               full_rejects++;
               push_expected(deq_pkg::ST_FULL, '0, 1'b1);
            end else begin
               if (act == deq_pkg::ACT_PUSH_FRONT) begin
                  shadow_front = (shadow_front + deq_pkg::DEPTH - 1) % deq_pkg::DEPTH;
                  shadow_store[shadow_front] = val;
               end else begin
                  shadow_store[(shadow_front + shadow_count) % deq_pkg::DEPTH] = val;
               end
               shadow_count++;
               push_expected(deq_pkg::ST_OK, '0, 1'b1);
            end
         end
         deq_pkg::ACT_POP_FRONT, deq_pkg::ACT_POP_BACK: begin
            if (shadow_count == 0) begin
               empty_reports++;
               push_expected(deq_pkg::ST_EMPTY, '0, 1'b1);
            end else if (act == deq_pkg::ACT_POP_FRONT) begin
               shadow_count--;
               push_expected(deq_pkg::ST_OK, shadow_store[shadow_front], 1'b1);
               shadow_front = (shadow_front + 1) % deq_pkg::DEPTH;
            end else begin
               shadow_count--;
               push_expected(deq_pkg::ST_OK,
                             shadow_store[(shadow_front + shadow_count) % deq_pkg::DEPTH],
                             1'b1);
            end
         end
         deq_pkg::ACT_DUMP: begin
            if (shadow_count == 0) begin
               empty_reports++;
               push_expected(deq_pkg::ST_EMPTY, '0, 1'b1);
            end else begin
               for (i = 0; i < shadow_count; i++) begin
                  push_expected(deq_pkg::ST_OK,
                                shadow_store[(shadow_front + i) % deq_pkg::DEPTH],
                                i == shadow_count - 1);
               end
               dump_beats += shadow_count;
            end
         end
         default: begin
            unknown_actions++;
            push_expected(deq_pkg::ST_OK, '0, 1'b1);
         end
      endcase
      if (shadow_count > peak_occupancy) begin
         peak_occupancy = shadow_count;
      end
   endtask

   function automatic deq_pkg::data_type pick_value();
      case ($urandom_range(0, 7))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return -32'sd1;
         3: return '0;
         default: return deq_pkg::data_type'($urandom);
      endcase
   endfunction

   // queues one request and tracks fill level so the sequences stay well formed
   task automatic queue_request(input logic [2:0] act, input deq_pkg::data_type val,
                                input int pct);
      deq_request_type q;
      q.action   = act;
      q.value    = val;
      q.idle_pct = pct;
      pending_requests.push_back(q);
      if ((act == deq_pkg::ACT_PUSH_FRONT || act == deq_pkg::ACT_PUSH_BACK) &&
          gen_count < deq_pkg::DEPTH) begin
         gen_count++;
      end else if ((act == deq_pkg::ACT_POP_FRONT || act == deq_pkg::ACT_POP_BACK) &&
                   gen_count > 0) begin
         gen_count--;
      end
   endtask

   task automatic queue_random_phase(input int n_items, input int pct);
      int stop_at;
      int n;
      int k;
      stop_at = pending_requests.size() + n_items;
      while (pending_requests.size() < stop_at) begin
         case ($urandom_range(0, 2))
            0: begin
               n = $urandom_range(3, 20);
               for (k = 0; k < n; k++) begin
                  queue_request($urandom_range(0, 1) ? deq_pkg::ACT_PUSH_BACK
                                                     : deq_pkg::ACT_PUSH_FRONT,
                                pick_value(), pct);
                  if ($urandom_range(0, 7) == 0) begin
                     queue_request(deq_pkg::ACT_DUMP, pick_value(), pct);
                  end
               end
               if (gen_count == deq_pkg::DEPTH && $urandom_range(0, 1)) begin
                  queue_request(deq_pkg::ACT_DUMP, pick_value(), pct);
               end
            end
            1: begin
               n = $urandom_range(3, 20);
               for (k = 0; k < n; k++) begin
                  queue_request($urandom_range(0, 1) ? deq_pkg::ACT_POP_BACK
                                                     : deq_pkg::ACT_POP_FRONT,
                                pick_value(), pct);
                  if ($urandom_range(0, 7) == 0) begin
                     queue_request(deq_pkg::ACT_DUMP, pick_value(), pct);
                  end
               end
            end
            default: begin
               n = $urandom_range(4, 12);
               for (k = 0; k < n; k++) begin
                  case ($urandom_range(0, 19))
                     0:       queue_request(3'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST)),
                                            pick_value(), pct);
                     1, 2:    queue_request(deq_pkg::ACT_DUMP, pick_value(), pct);
                     default: queue_request(3'($urandom_range(deq_pkg::ACT_PUSH_FRONT,
                                                              deq_pkg::ACT_POP_BACK)),
                                            pick_value(), pct);
                  endcase
               end
            end
         endcase
      end
   endtask

   // driver: a new beat goes out only once the previous one was taken
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || beat_taken) begin
         if (pending_requests.size() > 0 &&
             $urandom_range(0, 99) >= pending_requests[0].idle_pct) begin
            next_beat = pending_requests.pop_front();
            req_action <= next_beat.action;
            req_value  <= next_beat.value;
            start      <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: check result beats first, then predict for the request taken at this edge
   always @(posedge clock) begin
      deq_result_type exp_r;
      if (reset) begin
         beat_taken = 1'b0;
      end else begin
         beat_taken = start && !busy;
         if (rsp_valid !== 1'b0) begin
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("result beat with nothing expected, item %0d",
                                         rsp_item));
            end else begin
               exp_r = expected_results.pop_front();
               results_checked++;
               if (rsp_valid !== 1'b1)
                  report_mismatch("rsp_valid unknown");
               if (rsp_status !== exp_r.status)
                  report_mismatch($sformatf("status %0d, expected %s",
                                            rsp_status, exp_r.status.name()));
               if (rsp_item !== exp_r.item)
                  report_mismatch($sformatf("item %0d, expected %0d", rsp_item, exp_r.item));
               if (rsp_last !== exp_r.last)
                  report_mismatch($sformatf("last %b, expected %b", rsp_last, exp_r.last));
               if (rsp_occupancy !== exp_r.occ)
                  report_mismatch($sformatf("occupancy %0d, expected %0d",
                                            rsp_occupancy, exp_r.occ));
            end
         end
         if (beat_taken) begin
            items_accepted++;
            predict_deque_results(req_action, req_value);
         end
         if (beat_taken || rsp_valid === 1'b1) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
      $display("status: fail");
      $finish;
   end

   initial begin
      // directed: empty cases, reserved actions, value extremes, both ends
      queue_request(deq_pkg::ACT_DUMP,       -32'sd1, 0);
      queue_request(deq_pkg::ACT_POP_FRONT,  32'sh7fff_ffff, 0);
      queue_request(deq_pkg::ACT_POP_BACK,   32'sh8000_0000, 0);
      queue_request(ACT_UNUSED_FIRST,        32'sh1234_5678, 0);
      queue_request(ACT_UNUSED_FIRST + 3'd1, -32'sd1, 0);
      queue_request(ACT_UNUSED_LAST,         '0, 0);
      queue_request(deq_pkg::ACT_PUSH_FRONT, 32'sh8000_0000, 0);
      queue_request(deq_pkg::ACT_PUSH_BACK,  32'sh7fff_ffff, 0);
      queue_request(deq_pkg::ACT_PUSH_FRONT, -32'sd1, 0);
      queue_request(deq_pkg::ACT_PUSH_BACK,  '0, 0);
      queue_request(deq_pkg::ACT_DUMP,       '0, 0);
      queue_request(deq_pkg::ACT_POP_FRONT,  '0, 0);
      queue_request(deq_pkg::ACT_POP_BACK,   '0, 0);
      queue_request(ACT_UNUSED_LAST,         32'sh5555_aaaa, 0);
      queue_request(deq_pkg::ACT_POP_BACK,   '0, 0);
      queue_request(deq_pkg::ACT_POP_FRONT,  '0, 0);
      queue_request(deq_pkg::ACT_DUMP,       '0, 0);

      // fill past full, dump at full, drain past empty
      repeat (deq_pkg::DEPTH + 2)
         queue_request($urandom_range(0, 1) ? deq_pkg::ACT_PUSH_BACK : deq_pkg::ACT_PUSH_FRONT,
                       pick_value(), 0);
      queue_request(deq_pkg::ACT_DUMP, pick_value(), 0);
      repeat (deq_pkg::DEPTH + 2)
         queue_request($urandom_range(0, 1) ? deq_pkg::ACT_POP_BACK : deq_pkg::ACT_POP_FRONT,
                       pick_value(), 0);

      queue_random_phase(45, 0);
      queue_random_phase(95, 71);
      queue_random_phase(95, 0);
      queue_random_phase(95, 34);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_requests.size() > 0 || start) @(posedge clock);
      while (expected_results.size() > 0) @(posedge clock);
      repeat (deq_pkg::DEPTH + 4) @(posedge clock);

      $display("%0d requests taken, %0d result beats checked, %0d dump beats, peak fill %0d",
               items_accepted, results_checked, dump_beats, peak_occupancy);
      $display("%0d full rejects, %0d empty reports, %0d reserved actions, %0d mismatches",
               full_rejects, empty_reports, unknown_actions, mismatches);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
